// File: hw/rtl/isbn_cd_pkg.sv
// Shared types and constants for the ISBN check digit stream core.
// Used by every RTL module; depends on nothing.
`default_nettype none

package isbn_cd_pkg;

  localparam int MAX_RAW_LENGTH = 17;
  localparam int COUNT_W        = 5;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_X_UP  = 8'h58;
  localparam logic [7:0] CHAR_X_LOW = 8'h78;
  localparam logic [3:0] DIGIT_X    = 4'd10;

  localparam logic [COUNT_W-1:0] COUNT_MAX         = '1;
  localparam logic [COUNT_W-1:0] RAW_LIMIT         = COUNT_W'(MAX_RAW_LENGTH);
  localparam logic [COUNT_W-1:0] TEN_TAIL_POS      = 5'd9;
  localparam logic [COUNT_W-1:0] TEN_FULL_COUNT    = 5'd10;
  localparam logic [COUNT_W-1:0] THIRTEEN_TAIL_POS = 5'd12;
  localparam logic [COUNT_W-1:0] THIRTEEN_FULL     = 5'd13;
  localparam logic [3:0]         TEN_WEIGHT_TOP    = 4'd10;

  localparam logic [9:0] TEN_HEAD_MAX = 10'd540;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_MISMATCH  = 2'd1,
    STATUS_BAD_COUNT = 2'd2,
    STATUS_TOO_LONG  = 2'd3
  } status_t;

  typedef enum logic {
    OP_CHECK = 1'b0,
    OP_FIX   = 1'b1
  } op_t;

  typedef struct packed {
    logic               too_long;
    logic               op;
    logic [COUNT_W-1:0] digit_total;
    logic [9:0]         ten_head_sum;
    logic [3:0]         ten_tail_digit;
    logic [8:0]         thirteen_head_sum;
    logic [3:0]         thirteen_tail_digit;
  } snap_t;

endpackage

`default_nettype wire

// File: hw/rtl/isbn_cd_if.sv
// Channel interfaces of the ISBN check digit stream core: text characters in,
// results out. Valid/ready handshake; depends on nothing.
`default_nettype none

interface isbn_cd_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       op;
  logic       last;

  modport source(output valid, ch, op, last, input ready);
  modport sink(input valid, ch, op, last, output ready);
endinterface

interface isbn_cd_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] check_digit;
  logic       is_thirteen;
  logic [4:0] digit_total;

  modport source(output valid, status, check_digit, is_thirteen, digit_total, input ready);
  modport sink(input valid, status, check_digit, is_thirteen, digit_total, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/isbn_cd_accum.sv
// Input register and per-character accumulator: counts, ISBN-10 and ISBN-13 sums.
// Hands a snapshot of the final state to the resolve stage; uses isbn_cd_pkg.
`default_nettype none

module isbn_cd_accum (
  input  wire logic          clk,
  input  wire logic          rst,
  isbn_cd_text_if.sink       text,
  output logic               snap_valid,
  input  wire logic          snap_ready,
  output isbn_cd_pkg::snap_t snap
);

  logic       in_valid;
  logic [7:0] in_ch;
  logic       in_op;
  logic       in_last;

  logic [isbn_cd_pkg::COUNT_W-1:0] raw_count;
  logic [isbn_cd_pkg::COUNT_W-1:0] kept_count;
  logic [9:0]                      ten_head_sum;
  logic [3:0]                      ten_tail_digit;
  logic [8:0]                      thirteen_head_sum;
  logic [3:0]                      thirteen_tail_digit;

  logic [isbn_cd_pkg::COUNT_W-1:0] raw_count_next;
  logic [isbn_cd_pkg::COUNT_W-1:0] kept_count_next;
  logic [9:0]                      ten_head_sum_next;
  logic [3:0]                      ten_tail_digit_next;
  logic [8:0]                      thirteen_head_sum_next;
  logic [3:0]                      thirteen_tail_digit_next;

  logic       take;
  logic       is_digit;
  logic       kept;
  logic [3:0] value;
  logic [3:0] ten_weight;
  logic [7:0] ten_product;
  logic [5:0] thirteen_product;

  assign take       = in_valid && (!in_last || !snap_valid || snap_ready);
  assign text.ready = !in_valid || take;

  always_comb begin
    is_digit = (in_ch >= isbn_cd_pkg::CHAR_ZERO) && (in_ch <= isbn_cd_pkg::CHAR_NINE);
    kept     = is_digit || (in_ch == isbn_cd_pkg::CHAR_X_UP) ||
               (in_ch == isbn_cd_pkg::CHAR_X_LOW);
    value    = is_digit ? in_ch[3:0] : isbn_cd_pkg::DIGIT_X;

    ten_weight       = isbn_cd_pkg::TEN_WEIGHT_TOP - kept_count[3:0];
    ten_product      = 8'(value) * 8'(ten_weight);
    thirteen_product = kept_count[0] ? (6'({value, 1'b0}) + 6'(value)) : 6'(value);

    ten_head_sum_next        = ten_head_sum;
    ten_tail_digit_next      = ten_tail_digit;
    thirteen_head_sum_next   = thirteen_head_sum;
    thirteen_tail_digit_next = thirteen_tail_digit;
    kept_count_next          = kept_count;

    if (kept) begin
      if (kept_count < isbn_cd_pkg::TEN_TAIL_POS) begin
        ten_head_sum_next = ten_head_sum + 10'(ten_product);
      end else if (kept_count == isbn_cd_pkg::TEN_TAIL_POS) begin
        ten_tail_digit_next = value;
      end
      if (kept_count < isbn_cd_pkg::THIRTEEN_TAIL_POS) begin
        thirteen_head_sum_next = thirteen_head_sum + 9'(thirteen_product);
      end else if (kept_count == isbn_cd_pkg::THIRTEEN_TAIL_POS) begin
        thirteen_tail_digit_next = value;
      end
      if (kept_count != isbn_cd_pkg::COUNT_MAX) begin
        kept_count_next = kept_count + 1'b1;
      end
    end

    raw_count_next = (raw_count != isbn_cd_pkg::COUNT_MAX) ? raw_count + 1'b1 : raw_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.ready) begin
      in_valid <= text.valid;
    end
    if (text.ready && text.valid) begin
      in_ch   <= text.ch;
      in_op   <= text.op;
      in_last <= text.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_count           <= '0;
      kept_count          <= '0;
      ten_head_sum        <= '0;
      ten_tail_digit      <= '0;
      thirteen_head_sum   <= '0;
      thirteen_tail_digit <= '0;
      snap_valid          <= 1'b0;
    end else begin
      if (take && in_last) begin
        snap_valid <= 1'b1;
      end else if (snap_ready) begin
        snap_valid <= 1'b0;
      end
      if (take) begin
        if (in_last) begin
          raw_count           <= '0;
          kept_count          <= '0;
          ten_head_sum        <= '0;
          ten_tail_digit      <= '0;
          thirteen_head_sum   <= '0;
          thirteen_tail_digit <= '0;
        end else begin
          raw_count           <= raw_count_next;
          kept_count          <= kept_count_next;
          ten_head_sum        <= ten_head_sum_next;
          ten_tail_digit      <= ten_tail_digit_next;
          thirteen_head_sum   <= thirteen_head_sum_next;
          thirteen_tail_digit <= thirteen_tail_digit_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_last) begin
      snap.too_long            <= raw_count >= isbn_cd_pkg::RAW_LIMIT;
      snap.op                  <= in_op;
      snap.digit_total         <= kept_count_next;
      snap.ten_head_sum        <= ten_head_sum_next;
      snap.ten_tail_digit      <= ten_tail_digit_next;
      snap.thirteen_head_sum   <= thirteen_head_sum_next;
      snap.thirteen_tail_digit <= thirteen_tail_digit_next;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    take && in_last |=> kept_count == '0 && raw_count == '0)
    else $error("accumulator not cleared after last character");

  a_snap_hold: assert property (@(posedge clk) disable iff (rst)
    snap_valid && !snap_ready |=> snap_valid && $stable(snap))
    else $error("snapshot changed while stalled");

  a_ten_bound: assert property (@(posedge clk) disable iff (rst)
    ten_head_sum <= isbn_cd_pkg::TEN_HEAD_MAX)
    else $error("ISBN-10 head sum out of range");

endmodule

`default_nettype wire

// File: hw/rtl/isbn_cd_resolve.sv
// Resolve stage: turns a final snapshot into status and check digit, held in
// the result register. Uses isbn_cd_pkg and isbn_cd_result_if.
`default_nettype none

module isbn_cd_resolve (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                snap_valid,
  output logic                     snap_ready,
  input  wire isbn_cd_pkg::snap_t  snap,
  isbn_cd_result_if.source         result
);

  function automatic logic [3:0] mod11(input logic [9:0] x);
    logic [18:0] p;
    logic [6:0]  q;
    logic [9:0]  r;
    p = 19'(x) * 19'(373);
    q = p[18:12];
    r = x - (10'({q, 3'b000}) + 10'({q, 1'b0}) + 10'(q));
    return r[3:0];
  endfunction

  function automatic logic [3:0] mod10(input logic [8:0] x);
    logic [16:0] p;
    logic [5:0]  q;
    logic [8:0]  r;
    p = 17'(x) * 17'(205);
    q = p[16:11];
    r = x - (9'({q, 3'b000}) + 9'({q, 1'b0}));
    return r[3:0];
  endfunction

  logic                  out_valid;
  isbn_cd_pkg::status_t  out_status;
  logic [3:0]            out_check_digit;
  logic                  out_is_thirteen;
  logic [4:0]            out_digit_total;

  isbn_cd_pkg::status_t  status_next;
  logic [3:0]            check_digit_next;
  logic                  is_thirteen_next;
  logic                  fmt_ten;
  logic                  fmt_thirteen;
  logic                  partial;
  logic [3:0]            ten_rem;
  logic [3:0]            thirteen_rem;
  logic [4:0]            ten_check_sum;
  logic [4:0]            thirteen_check_sum;
  logic                  ten_ok;
  logic                  thirteen_ok;

  assign snap_ready = !out_valid || result.ready;

  always_comb begin
    fmt_ten      = (snap.digit_total == isbn_cd_pkg::TEN_TAIL_POS) ||
                   (snap.digit_total == isbn_cd_pkg::TEN_FULL_COUNT);
    fmt_thirteen = (snap.digit_total == isbn_cd_pkg::THIRTEEN_TAIL_POS) ||
                   (snap.digit_total == isbn_cd_pkg::THIRTEEN_FULL);
    partial      = (snap.digit_total == isbn_cd_pkg::TEN_TAIL_POS) ||
                   (snap.digit_total == isbn_cd_pkg::THIRTEEN_TAIL_POS);

    ten_rem            = mod11(snap.ten_head_sum);
    thirteen_rem       = mod10(snap.thirteen_head_sum);
    ten_check_sum      = 5'(ten_rem) + 5'(snap.ten_tail_digit);
    thirteen_check_sum = 5'(thirteen_rem) + 5'(snap.thirteen_tail_digit);
    ten_ok             = (ten_check_sum == 5'd0) || (ten_check_sum == 5'd11);
    thirteen_ok        = (thirteen_check_sum == 5'd0) || (thirteen_check_sum == 5'd10);

    status_next      = isbn_cd_pkg::STATUS_OK;
    check_digit_next = 4'd0;
    is_thirteen_next = 1'b0;

    if (snap.too_long) begin
      status_next = isbn_cd_pkg::STATUS_TOO_LONG;
    end else if (!(fmt_ten || fmt_thirteen) ||
                 (snap.op == isbn_cd_pkg::OP_CHECK && partial)) begin
      status_next = isbn_cd_pkg::STATUS_BAD_COUNT;
    end else begin
      is_thirteen_next = fmt_thirteen;
      if (snap.op == isbn_cd_pkg::OP_CHECK) begin
        if (fmt_thirteen ? !thirteen_ok : !ten_ok) begin
          status_next = isbn_cd_pkg::STATUS_MISMATCH;
        end
      end else if (fmt_thirteen) begin
        check_digit_next = (thirteen_rem == 4'd0) ? 4'd0 : 4'd10 - thirteen_rem;
      end else begin
        check_digit_next = (ten_rem == 4'd0) ? 4'd0 : 4'd11 - ten_rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_ready) begin
      out_valid <= snap_valid;
    end
    if (snap_ready && snap_valid) begin
      out_status      <= status_next;
      out_check_digit <= check_digit_next;
      out_is_thirteen <= is_thirteen_next;
      out_digit_total <= snap.digit_total;
    end
  end

  assign result.valid       = out_valid;
  assign result.status      = out_status;
  assign result.check_digit = out_check_digit;
  assign result.is_thirteen = out_is_thirteen;
  assign result.digit_total = out_digit_total;

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == isbn_cd_pkg::STATUS_TOO_LONG ||
                  out_status == isbn_cd_pkg::STATUS_BAD_COUNT)
    |-> out_check_digit == 4'd0 && !out_is_thirteen)
    else $error("rejected result carries a check digit or format");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_check_digit <= 4'd10)
    else $error("check digit out of range");

  a_snap_to_result: assert property (@(posedge clk) disable iff (rst)
    snap_valid && snap_ready |=> out_valid)
    else $error("snapshot taken without a result");

endmodule

`default_nettype wire

// File: hw/rtl/isbn_cd_core.sv
`default_nettype none
// ISBN check digit stream core, top level.
// Channel text carries one ASCII character per request (ch), the mode (op:
// 0 check, 1 compute the missing check digit, sampled with the last
// character) and last, which marks the final character of one ISBN text.
// Digits and x/X are kept, X worth 10; all other characters are dropped.
// Channel result carries one request per ISBN text: status, check_digit,
// is_thirteen and digit_total.
// Throughput: one character per cycle while text.ready is high, set by the
// accumulator between the input register and the snapshot register.
// The last character passes the input register, snapshot register and result
// register before the result is valid; a stalled receiver can hold it back.
// Reset clears all counts and sums and empties every stage; the block then
// takes text at once. Counts and sums clear after each last character.
// When the receiver stalls, the held result and one pending snapshot keep
// their values, and characters that end no text still flow in; text.ready
// drops only when a last character finds both held.
// Depends on isbn_cd_pkg, isbn_cd_if, isbn_cd_accum and isbn_cd_resolve.

module isbn_check_digit_stream_core (
  input  wire logic        clk,
  input  wire logic        rst,
  isbn_cd_text_if.sink     text,
  isbn_cd_result_if.source result
);

  logic               snap_valid;
  logic               snap_ready;
  isbn_cd_pkg::snap_t snap;

  isbn_cd_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  isbn_cd_resolve u_resolve (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .result     (result)
  );

endmodule

`default_nettype wire
